// File: hw/rtl/ocp_pkg.sv
`default_nettype none
package ocp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SC_W      = 18;
  localparam int CORDIC_N  = 18;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES = CORDIC_N / CORDIC_PER_STAGE;
  localparam int RED_STEPS = 8;
  localparam int RED_STAGES = RED_STEPS / 2;
  // reduction adds, steps, fold, cordic stages, rounding
  localparam int SC_LAT   = 1 + RED_STAGES + 1 + CORDIC_STAGES + 1;
  localparam int MATH_LAT = 5;
  localparam int PIPE_LAT = SC_LAT + MATH_LAT;

  localparam logic signed [SC_W-1:0] ONE_Q  = SC_W'(1 << FRAC_BITS);
  localparam logic signed [SC_W-1:0] MONE_Q = -ONE_Q;

  localparam logic [33:0] ANG_FULL  = 34'd23592960;
  localparam logic [33:0] ANG_BIAS  = 34'd2170552320;
  localparam logic signed [26:0] DEG90  = 27'sd5898240;
  localparam logic signed [26:0] DEG180 = 27'sd11796480;
  localparam logic signed [26:0] DEG360 = 27'sd23592960;
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  localparam logic [23:0] FOV_RESET = 24'd1966080;
  localparam logic [2:0]  ADDR_FALLBACK_FOV = 3'd0;

  typedef struct packed {
    logic signed [SC_W-1:0] s;
    logic signed [SC_W-1:0] c;
  } sincos_t;

  typedef struct packed {
    logic signed [31:0] ix;
    logic signed [31:0] iy;
    logic signed [31:0] iz;
    logic [31:0]        dmag;
    logic [23:0]        fov;
  } side_t;

  typedef struct packed {
    logic signed [31:0]     eye_x;
    logic signed [31:0]     eye_y;
    logic signed [31:0]     eye_z;
    logic signed [31:0]     ctr_x;
    logic signed [31:0]     ctr_y;
    logic signed [31:0]     ctr_z;
    logic signed [SC_W-1:0] up_x;
    logic signed [SC_W-1:0] up_y;
    logic signed [SC_W-1:0] up_z;
    logic [23:0]            fov;
  } pose_t;

  function automatic logic signed [26:0] atan_deg(input int i);
    case (i)
      0:  atan_deg = 27'sd2949120;
      1:  atan_deg = 27'sd1740967;
      2:  atan_deg = 27'sd919879;
      3:  atan_deg = 27'sd466945;
      4:  atan_deg = 27'sd234379;
      5:  atan_deg = 27'sd117304;
      6:  atan_deg = 27'sd58666;
      7:  atan_deg = 27'sd29335;
      8:  atan_deg = 27'sd14668;
      9:  atan_deg = 27'sd7334;
      10: atan_deg = 27'sd3667;
      11: atan_deg = 27'sd1833;
      12: atan_deg = 27'sd917;
      13: atan_deg = 27'sd458;
      14: atan_deg = 27'sd229;
      15: atan_deg = 27'sd115;
      16: atan_deg = 27'sd57;
      17: atan_deg = 27'sd29;
      default: atan_deg = 27'sd0;
    endcase
  endfunction

  function automatic logic signed [SC_W-1:0] qmul18(input logic signed [SC_W-1:0] a,
                                                   input logic signed [SC_W-1:0] b);
    logic signed [2*SC_W-1:0] p;
    p = a * b + (2*SC_W)'(1 << (FRAC_BITS-1));
    qmul18 = SC_W'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [SC_W-1:0] clamp_one(input logic signed [SC_W:0] v);
    if (v > (SC_W+1)'(ONE_Q)) clamp_one = ONE_Q;
    else if (v < (SC_W+1)'(MONE_Q)) clamp_one = MONE_Q;
    else clamp_one = SC_W'(v);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ocp_sincos.sv
`default_nettype none
module ocp_sincos import ocp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] angle_i,
  output sincos_t          sc_o
);

  logic [33:0] r_q [RED_STAGES+1];
  logic [33:0] r_d [RED_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= {{2{angle_i[31]}}, angle_i} + ANG_BIAS;
    end
  end

  for (genvar g = 0; g < RED_STAGES; g++) begin : g_red
    always_comb begin
      logic [33:0] t;
      t = r_q[g];
      for (int j = 0; j < 2; j++) begin
        if (t >= (ANG_FULL << (RED_STEPS - 1 - 2*g - j))) begin
          t = t - (ANG_FULL << (RED_STEPS - 1 - 2*g - j));
        end
      end
      r_d[g] = t;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) r_q[g+1] <= r_d[g];
    end
  end

  // fold to [-90,90] with sign flag
  logic signed [26:0] z_d;
  logic               neg_d;

  always_comb begin
    z_d   = 27'(r_q[RED_STAGES]);
    neg_d = 1'b0;
    if (z_d > DEG180) z_d = z_d - DEG360;
    if (z_d > DEG90) begin
      z_d   = z_d - DEG180;
      neg_d = 1'b1;
    end else if (z_d < -DEG90) begin
      z_d   = z_d + DEG180;
      neg_d = 1'b1;
    end
  end

  logic signed [33:0] cx_q [CORDIC_STAGES+1];
  logic signed [33:0] cy_q [CORDIC_STAGES+1];
  logic signed [26:0] cz_q [CORDIC_STAGES+1];
  logic               cn_q [CORDIC_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= CORDIC_K;
      cy_q[0] <= '0;
      cz_q[0] <= z_d;
      cn_q[0] <= neg_d;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    logic signed [33:0] x_d, y_d;
    logic signed [26:0] zz_d;
    always_comb begin
      logic signed [33:0] xs, ys;
      x_d  = cx_q[g];
      y_d  = cy_q[g];
      zz_d = cz_q[g];
      for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
        xs = x_d >>> (CORDIC_PER_STAGE*g + j);
        ys = y_d >>> (CORDIC_PER_STAGE*g + j);
        if (zz_d >= 0) begin
          x_d  = x_d - ys;
          y_d  = y_d + xs;
          zz_d = zz_d - atan_deg(CORDIC_PER_STAGE*g + j);
        end else begin
          x_d  = x_d + ys;
          y_d  = y_d - xs;
          zz_d = zz_d + atan_deg(CORDIC_PER_STAGE*g + j);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[g+1] <= x_d;
        cy_q[g+1] <= y_d;
        cz_q[g+1] <= zz_d;
        cn_q[g+1] <= cn_q[g];
      end
    end
  end

  function automatic logic signed [SC_W-1:0] round_q(input logic signed [33:0] v,
                                                    input logic neg);
    logic signed [33:0] t;
    logic signed [19:0] r;
    logic signed [SC_W-1:0] c;
    t = v + 34'sd8192;
    r = 20'(t >>> 14);
    if (r > 20'(ONE_Q)) c = ONE_Q;
    else if (r < 20'(MONE_Q)) c = MONE_Q;
    else c = SC_W'(r);
    round_q = neg ? -c : c;
  endfunction

  sincos_t sc_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q.c <= round_q(cx_q[CORDIC_STAGES], cn_q[CORDIC_STAGES]);
      sc_q.s <= round_q(cy_q[CORDIC_STAGES], cn_q[CORDIC_STAGES]);
    end
  end

  assign sc_o = sc_q;

endmodule
`default_nettype wire

// File: hw/rtl/ocp_pose_math.sv
`default_nettype none
module ocp_pose_math import ocp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  sincos_t   scx_i,
  input  sincos_t   scy_i,
  input  sincos_t   scz_i,
  input  side_t     side_i,
  output pose_t     pose_o
);

  side_t side_q [MATH_LAT-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < MATH_LAT-1; k++) side_q[k] <= side_q[k-1];
    end
  end

  // stage 1
  logic signed [SC_W-1:0] a_q, b_q, sysx_q, czcx_q, cysx_q, sycx_q, cycx_q, czsx_q;
  logic signed [SC_W-1:0] cy1_q, sy1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= qmul18(scz_i.s, scx_i.c);
      b_q    <= qmul18(scz_i.s, scx_i.s);
      sysx_q <= qmul18(scy_i.s, scx_i.s);
      czcx_q <= qmul18(scz_i.c, scx_i.c);
      cysx_q <= qmul18(scy_i.c, scx_i.s);
      sycx_q <= qmul18(scy_i.s, scx_i.c);
      cycx_q <= qmul18(scy_i.c, scx_i.c);
      czsx_q <= qmul18(scz_i.c, scx_i.s);
      cy1_q  <= scy_i.c;
      sy1_q  <= scy_i.s;
    end
  end

  // stage 2
  logic signed [SC_W-1:0] cya_q, sya_q, cyb_q, syb_q;
  logic signed [SC_W-1:0] sysx2_q, czcx2_q, cysx2_q, sycx2_q, cycx2_q, czsx2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cya_q   <= qmul18(cy1_q, a_q);
      sya_q   <= qmul18(sy1_q, a_q);
      cyb_q   <= qmul18(cy1_q, b_q);
      syb_q   <= qmul18(sy1_q, b_q);
      sysx2_q <= sysx_q;
      czcx2_q <= czcx_q;
      cysx2_q <= cysx_q;
      sycx2_q <= sycx_q;
      cycx2_q <= cycx_q;
      czsx2_q <= czsx_q;
    end
  end

  // stage 3
  logic signed [SC_W-1:0] up_q [3];
  logic signed [SC_W-1:0] fwd_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      up_q[0]  <= clamp_one((SC_W+1)'(cya_q) + (SC_W+1)'(sysx2_q));
      up_q[1]  <= czcx2_q;
      up_q[2]  <= clamp_one((SC_W+1)'(cysx2_q) - (SC_W+1)'(sya_q));
      fwd_q[0] <= clamp_one((SC_W+1)'(sycx2_q) - (SC_W+1)'(cyb_q));
      fwd_q[1] <= clamp_one(-(SC_W+1)'(czsx2_q));
      fwd_q[2] <= clamp_one((SC_W+1)'(cycx2_q) + (SC_W+1)'(syb_q));
    end
  end

  // stage 4: distance scaling
  logic signed [34:0]     m_q [3];
  logic signed [SC_W-1:0] up4_q [3];
  logic signed [SC_W-1:0] fwd4_q [3];
  for (genvar k = 0; k < 3; k++) begin : g_scale
    logic signed [50:0] p;
    always_comb begin
      p = signed'({1'b0, side_q[2].dmag}) * fwd_q[k] + 51'sd32768;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]    <= 35'(p >>> FRAC_BITS);
        up4_q[k]  <= up_q[k];
        fwd4_q[k] <= fwd_q[k];
      end
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (v < -37'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = 32'(v);
  endfunction

  // stage 5
  logic signed [36:0] eye_d [3];
  logic signed [36:0] ctr_d [3];
  always_comb begin
    eye_d[0] = 37'(side_q[3].ix) + 37'(m_q[0]);
    eye_d[1] = 37'(side_q[3].iy) + 37'(m_q[1]);
    eye_d[2] = 37'(side_q[3].iz) + 37'(m_q[2]);
    for (int k = 0; k < 3; k++) ctr_d[k] = eye_d[k] - 37'(fwd4_q[k]);
  end

  pose_t pose_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pose_q.eye_x <= sat32(eye_d[0]);
      pose_q.eye_y <= sat32(eye_d[1]);
      pose_q.eye_z <= sat32(eye_d[2]);
      pose_q.ctr_x <= sat32(ctr_d[0]);
      pose_q.ctr_y <= sat32(ctr_d[1]);
      pose_q.ctr_z <= sat32(ctr_d[2]);
      pose_q.up_x  <= up4_q[0];
      pose_q.up_y  <= up4_q[1];
      pose_q.up_z  <= up4_q[2];
      pose_q.fov   <= side_q[3].fov;
    end
  end

  assign pose_o = pose_q;

endmodule
`default_nettype wire

// File: hw/rtl/orbit_camera_pose_from_euler.sv
// channel | dir | tdata / tuser
// s_axis  | in  | interest xyz, angle xyz, distance, view_angle / mode_known, is_perspective
// m_axis  | out | eye xyz, center xyz, up xyz, fov_out / -
// apb     | in  | fallback_fov at 0x0
// One word per cycle while the output is not stalled; sine/cosine (angle reduction,
// CORDIC of two iterations per stage, rounding), then matrix and eye.
// The whole pipeline advances when the output word is taken or absent.
// rst_ni clears the valid bits and fallback_fov; data registers are not reset.
`default_nettype none
module orbit_camera_pose_from_euler import ocp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // ix[31:0] iy[63:32] iz[95:64] ax[127:96] ay[159:128] az[191:160]
  // distance[223:192] view_angle[247:224]
  input  wire logic [247:0] s_axis_tdata,
  // mode_known[0] is_perspective[1]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // eye xyz[95:0] center xyz[191:96] up xyz 18b each[245:192] fov_out[269:246] pad
  output logic [271:0]      m_axis_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [23:0] fov_q;
  logic        en;
  logic [PIPE_LAT-1:0] v_q;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FALLBACK_FOV) ? {8'd0, fov_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fov_q <= FOV_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_FALLBACK_FOV) begin
      fov_q <= pwdata[23:0];
    end
  end

  assign en            = m_axis_tready || !v_q[PIPE_LAT-1];
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  side_t side_d;
  side_t side_q [SC_LAT];

  always_comb begin
    side_d.ix   = s_axis_tdata[31:0];
    side_d.iy   = s_axis_tdata[63:32];
    side_d.iz   = s_axis_tdata[95:64];
    side_d.dmag = s_axis_tdata[223] ? 32'(-s_axis_tdata[223:192]) : s_axis_tdata[223:192];
    side_d.fov  = (!s_axis_tuser[0] || s_axis_tuser[1]) ? s_axis_tdata[247:224] : fov_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < SC_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  sincos_t scx, scy, scz;

  ocp_sincos u_sc_x (.clk_i, .en_i(en), .angle_i(s_axis_tdata[127:96]), .sc_o(scx));
  ocp_sincos u_sc_y (.clk_i, .en_i(en), .angle_i(s_axis_tdata[159:128]), .sc_o(scy));
  ocp_sincos u_sc_z (.clk_i, .en_i(en), .angle_i(s_axis_tdata[191:160]), .sc_o(scz));

  pose_t pose;

  ocp_pose_math u_math (
    .clk_i,
    .en_i   (en),
    .scx_i  (scx),
    .scy_i  (scy),
    .scz_i  (scz),
    .side_i (side_q[SC_LAT-1]),
    .pose_o (pose)
  );

  assign m_axis_tdata = {2'b00, pose.fov, pose.up_z, pose.up_y, pose.up_x,
                         pose.ctr_z, pose.ctr_y, pose.ctr_x,
                         pose.eye_z, pose.eye_y, pose.eye_x};

  a_up_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pose.up_x <= ONE_Q && pose.up_x >= MONE_Q &&
                       pose.up_y <= ONE_Q && pose.up_y >= MONE_Q &&
                       pose.up_z <= ONE_Q && pose.up_z >= MONE_Q))
    else $error("up vector out of range");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("valid bits moved during stall");

  a_words_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !s_axis_tvalid && !v_q[PIPE_LAT-1]) |=> $countones(v_q) == $past($countones(v_q)))
    else $error("word lost or invented in pipeline");

endmodule
`default_nettype wire

// File: verif/tb_orbit_camera_pose_from_euler.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_orbit_camera_pose_from_euler;
  import ocp_pkg::*;

  typedef struct packed {
    logic [1:0]   tuser;
    logic [247:0] tdata;
  } sample_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = PIPE_LAT + 10;
  localparam longint ONE = 64'sd1 << FRAC_BITS;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [247:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [271:0] m_axis_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  orbit_camera_pose_from_euler DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  sample_t pending_words[$];
  logic [271:0] expected_poses[$];
  logic [23:0] fov_reg = FOV_RESET;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  bit hold_src = 1'b0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint fxmul(longint a, longint b);
    return asr(a * b + (64'sd1 << (FRAC_BITS - 1)), FRAC_BITS);
  endfunction

  function automatic void sin_cos(longint ang, output longint s, output longint c);
    longint full, r, z, x, y, xs, ys, half;
    bit flip;
    full = 64'sd360 << FRAC_BITS;
    r = ang % full;
    if (r < 0) r += full;
    z = r;
    flip = 1'b0;
    x = 64'sd652032874;
    y = 0;
    if (z > 180 * 64'sd65536) z -= 360 * 64'sd65536;
    if (z > 90 * 64'sd65536) begin
      z -= 180 * 64'sd65536;
      flip = 1'b1;
    end else if (z < -90 * 64'sd65536) begin
      z += 180 * 64'sd65536;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_deg(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_deg(i));
      end
    end
    half = 64'sd1 << (30 - FRAC_BITS - 1);
    c = clip(asr(x + half, 30 - FRAC_BITS), -ONE, ONE);
    s = clip(asr(y + half, 30 - FRAC_BITS), -ONE, ONE);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic logic [271:0] camera_pose(sample_t w);
    longint sx, cx, sy, cy, sz, cz, a, b, d;
    longint ip[3], up[3], fwd[3], eye, ctr;
    logic [271:0] r;
    logic [23:0] fov;
    r = '0;
    sin_cos(longint'($signed(w.tdata[127:96])), sx, cx);
    sin_cos(longint'($signed(w.tdata[159:128])), sy, cy);
    sin_cos(longint'($signed(w.tdata[191:160])), sz, cz);
    d = longint'($signed(w.tdata[223:192]));
    if (d < 0) d = -d;
    for (int k = 0; k < 3; k++) ip[k] = longint'($signed(w.tdata[32*k +: 32]));
    a = fxmul(sz, cx);
    b = fxmul(sz, sx);
    up[0] = fxmul(cy, a) + fxmul(sy, sx);
    up[1] = fxmul(cz, cx);
    up[2] = fxmul(cy, sx) - fxmul(sy, a);
    fwd[0] = fxmul(sy, cx) - fxmul(cy, b);
    fwd[1] = -fxmul(cz, sx);
    fwd[2] = fxmul(cy, cx) + fxmul(sy, b);
    for (int k = 0; k < 3; k++) begin
      up[k] = clip(up[k], -ONE, ONE);
      fwd[k] = clip(fwd[k], -ONE, ONE);
      eye = ip[k] + fxmul(d, fwd[k]);
      ctr = clip(eye - fwd[k], -64'sd2147483648, 64'sd2147483647);
      eye = clip(eye, -64'sd2147483648, 64'sd2147483647);
      r[32*k +: 32] = eye[31:0];
      r[96 + 32*k +: 32] = ctr[31:0];
      r[192 + 18*k +: 18] = up[k][17:0];
    end
    if (!w.tuser[0] || w.tuser[1]) fov = w.tdata[247:224];
    else fov = fov_reg;
    r[269:246] = fov;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_poses.push_back(camera_pose('{s_axis_tuser, s_axis_tdata}));
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_words.size() > 0 && !hold_src &&
          $urandom_range(99) >= src_idle_pct) begin
        sample_t w;
        w = pending_words.pop_front();
        s_axis_tdata <= w.tdata;
        s_axis_tuser <= w.tuser;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        logic [271:0] e;
        e = expected_poses.pop_front();
        for (int k = 0; k < 6; k++)
          if (e[32*k +: 32] !== m_axis_tdata[32*k +: 32]) begin
            $display("%0t: eye/center field %0d expected %h actual %h", $time, k,
                     e[32*k +: 32], m_axis_tdata[32*k +: 32]);
            errors++;
          end
        for (int k = 0; k < 3; k++)
          if (e[192 + 18*k +: 18] !== m_axis_tdata[192 + 18*k +: 18]) begin
            $display("%0t: up field %0d expected %h actual %h", $time, k,
                     e[192 + 18*k +: 18], m_axis_tdata[192 + 18*k +: 18]);
            errors++;
          end
        if (e[269:246] !== m_axis_tdata[269:246]) begin
          $display("%0t: fov expected %h actual %h", $time, e[269:246],
                   m_axis_tdata[269:246]);
          errors++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(720)) - 360) << 16;
      2: return 32'($signed($urandom_range(1440)) - 720) << 15;
      3: return $urandom_range(32'h7fff) << $urandom_range(16);
      4: return 32'($signed(($urandom_range(8) * 45 - 180)) << 16) + $urandom_range(3) - 1;
      default: return 32'($signed($urandom_range(400000)) - 200000) << 6;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t w;
    for (int k = 0; k < 3; k++)
      w.tdata[32*k +: 32] = ($urandom_range(3) == 0) ? $urandom()
                             : 32'($signed($urandom_range(2000000)) - 1000000);
    for (int k = 3; k < 6; k++) w.tdata[32*k +: 32] = pick_angle();
    case ($urandom_range(3))
      0: w.tdata[223:192] = $urandom();
      1: w.tdata[223:192] = 32'($signed($urandom_range(40)) - 20) << 16;
      default: w.tdata[223:192] = 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
    w.tdata[247:224] = ($urandom_range(7) == 0) ? 24'($urandom())
                       : 24'($urandom_range(11796480));
    w.tuser = 2'($urandom());
    return w;
  endfunction

  function automatic sample_t directed_sample(logic [31:0] v, logic [31:0] ang,
                                              logic [31:0] d, logic [23:0] fov,
                                              logic [1:0] u);
    sample_t w;
    for (int k = 0; k < 3; k++) w.tdata[32*k +: 32] = v;
    for (int k = 3; k < 6; k++) w.tdata[32*k +: 32] = ang;
    w.tdata[223:192] = d;
    w.tdata[247:224] = fov;
    w.tuser = u;
    return w;
  endfunction

  task automatic write_fov(logic [23:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_FALLBACK_FOV; pwdata <= {8'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    fov_reg = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // checked on the falling edge, once the driver's updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_words.size() > 0 || s_axis_tvalid || expected_poses.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [23:0] fov_settings[4];
    int idle_src[4];
    int idle_sink[4];
    fov_settings = '{24'd0, 24'd11796480, 24'hffffff, 24'd4325376};
    idle_src = '{0, 55, 0, 36};
    idle_sink = '{0, 0, 55, 36};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    pending_words.push_back(directed_sample(32'h0, 32'h0, 32'h0, 24'd0, 2'b00));
    pending_words.push_back(directed_sample(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                            24'hffffff, 2'b11));
    pending_words.push_back(directed_sample(32'h80000000, 32'h80000000, 32'h80000000,
                                            24'd11796480, 2'b01));
    pending_words.push_back(directed_sample(32'h7fffffff, 32'h0, 32'h80000000,
                                            24'd100, 2'b10));
    pending_words.push_back(directed_sample(32'h80000000, 32'h005a0000, 32'h7fffffff,
                                            24'd5, 2'b01));
    pending_words.push_back(directed_sample(32'h0, 32'h00b40000, 32'h00010000,
                                            24'd5898240, 2'b11));
    pending_words.push_back(directed_sample(32'h0, 32'hff4c0000, 32'h00010000,
                                            24'd1, 2'b00));
    pending_words.push_back(directed_sample(32'h0, 32'h01680000, 32'hffff0000,
                                            24'd2, 2'b01));
    pending_words.push_back(directed_sample(32'h0, 32'hffa60000, 32'h00640000,
                                            24'd3, 2'b10));
    pending_words.push_back(directed_sample(32'hffffffff, 32'h00b40001, 32'h1,
                                            24'd4, 2'b11));
    pending_words.push_back(directed_sample(32'h1, 32'h005a0001, 32'hffffffff,
                                            24'd6, 2'b01));
    pending_words.push_back(directed_sample(32'h12345678, 32'h002d0000, 32'h40000000,
                                            24'd7, 2'b00));
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      write_fov(fov_settings[phase]);
      src_idle_pct = idle_src[phase];
      sink_stall_pct = idle_sink[phase];
      for (int n = 0; n < 400; n++) pending_words.push_back(random_sample());
      if (phase == 1) begin
        while (pending_words.size() > 200) @(posedge clk_i);
        hold_src = 1'b1;
        do @(negedge clk_i);
        while (s_axis_tvalid || expected_poses.size() > 0);
        hold_src = 1'b0;
      end
      wait_drained();
    end
    sink_stall_pct = 0;
    write_fov(FOV_RESET);
    for (int n = 0; n < 20; n++) pending_words.push_back(random_sample());
    wait_drained();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
